### rtl/core/pcrq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrq_pkg: shared types and constants of the requant shift core
// Table depth, field widths, register codes and the configuration bundle.
// ----------------------------------------------------------------------------
package pcrq_pkg;

  // Table depth, a power of two.
  localparam int unsigned MAX_CHANNELS = 256;
  localparam int unsigned CH_W         = $clog2(MAX_CHANNELS);

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned GRP_W   = 21;
  localparam int unsigned PLANE_W = 20;
  localparam int unsigned BOUND_W = 9;
  localparam int unsigned OUT_W   = 8;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned SHIFT_W = 5;

  localparam logic [GRP_W-1:0] PLANE_LIMIT = GRP_W'(1 << PLANE_W);

  typedef enum logic [2:0] {
    CFG_CONTROL  = 3'd0,
    CFG_GROUP    = 3'd1,
    CFG_SHIFT    = 3'd2,
    CFG_IN_OFF   = 3'd3,
    CFG_OUT_OFF  = 3'd4,
    CFG_OUT_LOW  = 3'd5,
    CFG_OUT_HIGH = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    FMT_U8  = 3'd0,
    FMT_U16 = 3'd1,
    FMT_U32 = 3'd2,
    FMT_S8  = 3'd3,
    FMT_S16 = 3'd4,
    FMT_S32 = 3'd5
  } fmt_e;

  typedef struct packed {
    logic [2:0]                fmt;
    logic                      chan_first;
    logic                      round_en;
    logic [GRP_W-1:0]          group_len;
    logic [SHIFT_W-1:0]        shift;
    logic signed [DATA_W-1:0]  in_off;
    logic signed [DATA_W-1:0]  out_off;
    logic signed [BOUND_W-1:0] out_lo;
    logic signed [BOUND_W-1:0] out_hi;
  } cfg_t;

endpackage

### rtl/core/pcrq_coef_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrq_coef_mem: per-channel multiplier and addend store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pcrq_coef_mem (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [pcrq_pkg::CH_W-1:0]              waddr_i,
  input  logic [pcrq_pkg::DATA_W-1:0]            wmul_i,
  input  logic [pcrq_pkg::DATA_W-1:0]            wadd_i,
  input  logic                                   re_i,
  input  logic [pcrq_pkg::CH_W-1:0]              raddr_i,
  output logic [pcrq_pkg::DATA_W-1:0]            rmul_o,
  output logic [pcrq_pkg::DATA_W-1:0]            radd_o
);

  logic [2*pcrq_pkg::DATA_W-1:0] mem_q [pcrq_pkg::MAX_CHANNELS];
  logic [2*pcrq_pkg::DATA_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= {wmul_i, wadd_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_q <= mem_q[raddr_i];
    end
  end

  assign rmul_o = rd_q[2*pcrq_pkg::DATA_W-1:pcrq_pkg::DATA_W];
  assign radd_o = rd_q[pcrq_pkg::DATA_W-1:0];

endmodule

### rtl/core/pcrq_chan_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrq_chan_track: channel and plane position counters
// Gives the channel of the sample being accepted and steps the counters.
// ----------------------------------------------------------------------------
module pcrq_chan_track (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  logic                              first_i,
  input  logic                              chan_first_i,
  input  logic [pcrq_pkg::GRP_W-1:0]        group_len_i,
  output logic [pcrq_pkg::CH_W-1:0]         chan_o
);

  localparam int unsigned CH_W = pcrq_pkg::CH_W;
  localparam int unsigned GRP_W = pcrq_pkg::GRP_W;
  localparam int unsigned PLANE_W = pcrq_pkg::PLANE_W;

  logic [CH_W-1:0]    ch_q, ch_d, cur_ch;
  logic [PLANE_W-1:0] pl_q, pl_d, cur_pl;
  logic [GRP_W-1:0]   g_eff;
  logic [GRP_W-1:0]   pl_inc;
  logic [CH_W:0]      ch_inc;
  logic [CH_W-1:0]    ch_wrap;

  // Zero acts as one, large values saturate at the plane limit.
  always_comb begin
    if (group_len_i == '0) begin
      g_eff = GRP_W'(1);
    end else if (group_len_i > pcrq_pkg::PLANE_LIMIT) begin
      g_eff = pcrq_pkg::PLANE_LIMIT;
    end else begin
      g_eff = group_len_i;
    end
  end

  assign cur_ch = first_i ? '0 : ch_q;
  assign cur_pl = first_i ? '0 : pl_q;
  assign chan_o = cur_ch;

  assign pl_inc  = GRP_W'(cur_pl) + GRP_W'(1);
  assign ch_inc  = (CH_W+1)'(cur_ch) + (CH_W+1)'(1);
  assign ch_wrap = (cur_ch == CH_W'(pcrq_pkg::MAX_CHANNELS - 1)) ? '0 : ch_inc[CH_W-1:0];

  always_comb begin
    ch_d = ch_q;
    pl_d = pl_q;
    if (accept_i) begin
      if (chan_first_i) begin
        if (pl_inc >= g_eff) begin
          pl_d = '0;
          ch_d = ch_wrap;
        end else begin
          pl_d = pl_inc[PLANE_W-1:0];
          ch_d = cur_ch;
        end
      end else begin
        pl_d = cur_pl;
        if (GRP_W'(ch_inc) >= g_eff ||
            ch_inc >= (CH_W+1)'(pcrq_pkg::MAX_CHANNELS)) begin
          ch_d = '0;
        end else begin
          ch_d = ch_inc[CH_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q <= '0;
      pl_q <= '0;
    end else begin
      ch_q <= ch_d;
      pl_q <= pl_d;
    end
  end

  // Counters move only on sample requests.
  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept_i |=> $stable(ch_q) && $stable(pl_q))
    else $error("position counters moved without a sample request");

endmodule

### rtl/core/pcrq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrq_datapath: offset, multiply-add, shift, clamp pipeline
// Four register stages with per-stage valid and backpressure.
// ----------------------------------------------------------------------------
module pcrq_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               load_i,
  input  logic [pcrq_pkg::DATA_W-1:0]        sample_i,
  input  pcrq_pkg::cfg_t                     cfg_i,
  input  logic [pcrq_pkg::DATA_W-1:0]        mul_i,
  input  logic [pcrq_pkg::DATA_W-1:0]        add_i,
  input  logic                               out_ready_i,
  output logic                               s1_ready_o,
  output logic                               out_valid_o,
  output logic [pcrq_pkg::OUT_W-1:0]         value_o
);

  localparam int unsigned DATA_W = pcrq_pkg::DATA_W;

  logic              v1_q, v2_q, v3_q, v4_q;
  logic              rdy1, rdy2, rdy3, rdy4;
  logic [DATA_W-1:0] ext, x1_d, x1_q;
  logic [DATA_W-1:0] prod_d, prod_q, add2_q;
  logic [DATA_W-1:0] rnd, sum_d, sum_q;
  logic signed [DATA_W-1:0] shifted, biased, lo, hi, clamped;
  logic [pcrq_pkg::OUT_W-1:0] res_q;

  assign rdy4 = !v4_q || out_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s1_ready_o = rdy1;

  // Input format extension.
  always_comb begin
    unique case (cfg_i.fmt)
      pcrq_pkg::FMT_U8:  ext = {{(DATA_W-8){1'b0}}, sample_i[7:0]};
      pcrq_pkg::FMT_U16: ext = {{(DATA_W-16){1'b0}}, sample_i[15:0]};
      pcrq_pkg::FMT_S8:  ext = {{(DATA_W-8){sample_i[7]}}, sample_i[7:0]};
      pcrq_pkg::FMT_S16: ext = {{(DATA_W-16){sample_i[15]}}, sample_i[15:0]};
      default:           ext = sample_i;
    endcase
  end

  assign x1_d   = ext + cfg_i.in_off;
  assign prod_d = DATA_W'(x1_q * mul_i);

  // Round half up, skipped for a zero shift.
  assign rnd   = (cfg_i.round_en && cfg_i.shift != '0) ?
                 (DATA_W'(1) << (cfg_i.shift - 5'd1)) : '0;
  assign sum_d = prod_q + add2_q + rnd;

  assign shifted = $signed(sum_q) >>> cfg_i.shift;
  assign biased  = shifted + cfg_i.out_off;
  assign lo      = DATA_W'(cfg_i.out_lo);
  assign hi      = DATA_W'(cfg_i.out_hi);

  // Raise to low first, then cut to high.
  always_comb begin
    clamped = biased;
    if (clamped < lo) begin
      clamped = lo;
    end
    if (clamped > hi) begin
      clamped = hi;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= load_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      x1_q <= x1_d;
    end
    if (rdy2 && v1_q) begin
      prod_q <= prod_d;
      add2_q <= add_i;
    end
    if (rdy3 && v2_q) begin
      sum_q <= sum_d;
    end
    if (rdy4 && v3_q) begin
      res_q <= clamped[pcrq_pkg::OUT_W-1:0];
    end
  end

  assign out_valid_o = v4_q;
  assign value_o     = res_q;

  // A stalled result freezes the stage behind it.
  a_s3_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && v4_q && !out_ready_i |=> v3_q && $stable(sum_q))
    else $error("stage 3 changed under output stall");

  // Input is refused only when every stage is occupied.
  a_full_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_ready_o |-> v1_q && v2_q && v3_q && v4_q)
    else $error("input refused with a free stage");

endmodule

### rtl/core/per_channel_requant_shift_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_channel_requant_shift_core: per-channel requantization to 8 bits
// Requests with func 1 carry a sample that is extended by the input format,
// offset, multiplied and added with its channel's coefficients (32-bit
// wrapping), shifted right arithmetically with optional round-half-up,
// offset again and clamped signed to [output_low, output_high]; the low
// 8 bits are returned, one result per sample. Requests with func 0 load one
// coefficient entry and return nothing. One request is taken every clock
// cycle while the output side keeps up. The request edge loads the
// coefficient read and the offset sample into the first stage, then the
// multiplier, add/round and shift/clamp stages follow in that order; the
// shift/clamp register holds the valid result. The four stages stall
// independently, so bubbles are squeezed out under backpressure.
// Coefficient tables power up undefined and are not cleared; a sample may
// only use entries that were loaded. The channel comes from a position
// counter: modulo group_length (channels-last) or divided by it
// (channels-first), wrapping at the table depth; first_item restarts it.
// Configuration registers are written through a plain write port; the user
// must write them only while no request is in flight; not enforced here.
// ----------------------------------------------------------------------------
module per_channel_requant_shift_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // request channel
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  func_i,
  input  logic                                  first_item_i,
  input  logic [pcrq_pkg::IDX_W-1:0]            coef_index_i,
  input  logic signed [pcrq_pkg::DATA_W-1:0]    coef_mul_i,
  input  logic signed [pcrq_pkg::DATA_W-1:0]    coef_add_i,
  input  logic [pcrq_pkg::DATA_W-1:0]           sample_i,
  // result channel
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [pcrq_pkg::OUT_W-1:0]            value_out_o,
  // configuration
  input  logic                                  cfg_we_i,
  input  logic [2:0]                            cfg_index_i,
  input  logic [pcrq_pkg::DATA_W-1:0]           cfg_wdata_i
);

  pcrq_pkg::cfg_t cfg_q;

  logic                        in_accept;
  logic                        coef_wr;
  logic                        smp_accept;
  logic [pcrq_pkg::CH_W-1:0]   chan;
  logic [pcrq_pkg::DATA_W-1:0] rd_mul, rd_add;

  assign in_accept  = in_valid_i && in_ready_o;
  assign coef_wr    = in_accept && !func_i;
  assign smp_accept = in_accept && func_i;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fmt        <= pcrq_pkg::FMT_U8;
      cfg_q.chan_first <= 1'b0;
      cfg_q.round_en   <= 1'b0;
      cfg_q.group_len  <= pcrq_pkg::GRP_W'(1);
      cfg_q.shift      <= '0;
      cfg_q.in_off     <= '0;
      cfg_q.out_off    <= '0;
      cfg_q.out_lo     <= -pcrq_pkg::BOUND_W'(128);
      cfg_q.out_hi     <= pcrq_pkg::BOUND_W'(127);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pcrq_pkg::CFG_CONTROL: begin
          cfg_q.fmt        <= cfg_wdata_i[2:0];
          cfg_q.chan_first <= cfg_wdata_i[3];
          cfg_q.round_en   <= cfg_wdata_i[4];
        end
        pcrq_pkg::CFG_GROUP:    cfg_q.group_len <= cfg_wdata_i[pcrq_pkg::GRP_W-1:0];
        pcrq_pkg::CFG_SHIFT:    cfg_q.shift     <= cfg_wdata_i[pcrq_pkg::SHIFT_W-1:0];
        pcrq_pkg::CFG_IN_OFF:   cfg_q.in_off    <= cfg_wdata_i;
        pcrq_pkg::CFG_OUT_OFF:  cfg_q.out_off   <= cfg_wdata_i;
        pcrq_pkg::CFG_OUT_LOW:  cfg_q.out_lo    <= cfg_wdata_i[pcrq_pkg::BOUND_W-1:0];
        pcrq_pkg::CFG_OUT_HIGH: cfg_q.out_hi    <= cfg_wdata_i[pcrq_pkg::BOUND_W-1:0];
        default: ;
      endcase
    end
  end

  // Channel for the sample being taken this cycle.
  pcrq_chan_track u_chan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (smp_accept),
    .first_i      (first_item_i),
    .chan_first_i (cfg_q.chan_first),
    .group_len_i  (cfg_q.group_len),
    .chan_o       (chan)
  );

  // Coefficient write and sample read share the request edge; a write is
  // visible to any sample taken on a later edge.
  pcrq_coef_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (coef_wr),
    .waddr_i (pcrq_pkg::CH_W'(coef_index_i)),
    .wmul_i  (coef_mul_i),
    .wadd_i  (coef_add_i),
    .re_i    (smp_accept),
    .raddr_i (chan),
    .rmul_o  (rd_mul),
    .radd_o  (rd_add)
  );

  pcrq_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (smp_accept),
    .sample_i    (sample_i),
    .cfg_i       (cfg_q),
    .mul_i       (rd_mul),
    .add_i       (rd_add),
    .out_ready_i (out_ready_i),
    .s1_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .value_o     (value_out_o)
  );

endmodule
